FILE: rtl/bilinear_pixel_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// bilinear pixel blend unit assertion macros
// shared concurrent assertion forms for the blend unit modules
// ----------------------------------------------------------------------------
`ifndef BILINEAR_PIXEL_BLEND_UNIT_DEFINES_SVH
`define BILINEAR_PIXEL_BLEND_UNIT_DEFINES_SVH

// same-cycle implication
`define BPB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// shared widths, register map, sample format type and sample bias function
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int FRAC_W            = 12;
  localparam int FRAC_EXT_W        = 16;
  localparam int SAMPLE_W          = 16;
  localparam int FRAC_BITS_DEFAULT = 12;
  localparam int NUM_TAPS          = 4;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_IDX_SAMPLE_FORMAT = 1'b0;

  typedef struct packed {
    logic wide;
    logic sgn;
  } fmt_t;

  // flip the sign bit of signed formats and mask 8-bit formats
  function automatic logic [SAMPLE_W-1:0] bias_sample(logic [SAMPLE_W-1:0] raw, fmt_t f);
    logic [SAMPLE_W-1:0] v;
    v = f.wide ? raw : {8'h00, raw[7:0]};
    if (f.sgn) begin
      if (f.wide) begin
        v[15] = ~v[15];
      end else begin
        v[7] = ~v[7];
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/bpb_in_if.sv
// ----------------------------------------------------------------------------
// bpb_in_if
// input channel: fractional position and four corner samples
// ----------------------------------------------------------------------------
interface bpb_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpb_pkg::FRAC_W-1:0]    frac_x;
  logic [bpb_pkg::FRAC_W-1:0]    frac_y;
  logic [bpb_pkg::SAMPLE_W-1:0]  top_left;
  logic [bpb_pkg::SAMPLE_W-1:0]  top_right;
  logic [bpb_pkg::SAMPLE_W-1:0]  bottom_left;
  logic [bpb_pkg::SAMPLE_W-1:0]  bottom_right;

  modport source (output valid, frac_x, frac_y, top_left, top_right, bottom_left,
                  bottom_right, input ready);
  modport sink (input valid, frac_x, frac_y, top_left, top_right, bottom_left,
                bottom_right, output ready);
endinterface

FILE: rtl/bpb_out_if.sv
// ----------------------------------------------------------------------------
// bpb_out_if
// output channel: blended sample
// ----------------------------------------------------------------------------
interface bpb_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpb_pkg::SAMPLE_W-1:0]  blended;

  modport source (output valid, blended, input ready);
  modport sink (input valid, blended, output ready);
endinterface

FILE: rtl/bpb_cfg.sv
// ----------------------------------------------------------------------------
// bpb_cfg
// apb register slave holding the sample format
// ----------------------------------------------------------------------------
`include "bilinear_pixel_blend_unit_defines.svh"

module bpb_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bpb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bpb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bpb_pkg::fmt_t                    fmt
);

  logic                           wr_en;
  logic [bpb_pkg::REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bpb_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready &&
                   (reg_idx == bpb_pkg::REG_IDX_SAMPLE_FORMAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= '0;
    end else if (wr_en) begin
      fmt <= bpb_pkg::fmt_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == bpb_pkg::REG_IDX_SAMPLE_FORMAT) begin
      prdata[1:0] = {fmt.wide, fmt.sgn};
    end
  end

  `BPB_ASSERT_NEXT(a_fmt_write, clk, rst, wr_en, {fmt.wide, fmt.sgn} == $past(pwdata[1:0]), "sample format write lost")

endmodule

FILE: rtl/bpb_weight.sv
// ----------------------------------------------------------------------------
// bpb_weight
// three-stage weight generator: capture and bias, fraction products, weights
// ----------------------------------------------------------------------------
`include "bilinear_pixel_blend_unit_defines.svh"

module bpb_weight #(
  parameter int FRAC_BITS = bpb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bpb_pkg::fmt_t                 fmt,
  bpb_in_if.sink                        pix_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpb_pkg::fmt_t                 out_fmt,
  output logic [FRAC_BITS:0]            out_wgt [bpb_pkg::NUM_TAPS],
  output logic [bpb_pkg::SAMPLE_W-1:0]  out_smp [bpb_pkg::NUM_TAPS]
);

  localparam int SUM_W = FRAC_BITS + 3;
  localparam int unsigned SCALE = 1 << FRAC_BITS;
  localparam logic [FRAC_BITS:0] SCALE_V = {1'b1, {FRAC_BITS{1'b0}}};

  logic ready_a, ready_b, ready_c;
  logic va, vb, vc;

  logic [bpb_pkg::FRAC_EXT_W-1:0] fx_ext, fy_ext;

  // stage a
  logic [FRAC_BITS-1:0]           fx_a, fy_a;
  logic [FRAC_BITS:0]             yd_a;
  bpb_pkg::fmt_t                  fmt_a;
  logic [bpb_pkg::SAMPLE_W-1:0]   smp_a [bpb_pkg::NUM_TAPS];

  // stage b
  logic [FRAC_BITS-1:0]           fy_b;
  logic [FRAC_BITS:0]             yd_b, c2_b, c4_b;
  bpb_pkg::fmt_t                  fmt_b;
  logic [bpb_pkg::SAMPLE_W-1:0]   smp_b [bpb_pkg::NUM_TAPS];
  logic [2*FRAC_BITS-1:0]         prod_lo;
  logic [2*FRAC_BITS:0]           prod_hi;

  assign ready_c = !vc || out_ready;
  assign ready_b = !vb || ready_c;
  assign ready_a = !va || ready_b;
  assign pix_in.ready = ready_a;

  assign fx_ext = bpb_pkg::FRAC_EXT_W'(pix_in.frac_x);
  assign fy_ext = bpb_pkg::FRAC_EXT_W'(pix_in.frac_y);

  assign prod_lo = fy_a * fx_a;
  assign prod_hi = yd_a * fx_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ready_a) va <= pix_in.valid;
      if (ready_b) vb <= va;
      if (ready_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      fx_a     <= fx_ext[FRAC_BITS-1:0];
      fy_a     <= fy_ext[FRAC_BITS-1:0];
      yd_a     <= SCALE_V - {1'b0, fy_ext[FRAC_BITS-1:0]};
      fmt_a    <= fmt;
      smp_a[0] <= bpb_pkg::bias_sample(pix_in.top_left, fmt);
      smp_a[1] <= bpb_pkg::bias_sample(pix_in.top_right, fmt);
      smp_a[2] <= bpb_pkg::bias_sample(pix_in.bottom_left, fmt);
      smp_a[3] <= bpb_pkg::bias_sample(pix_in.bottom_right, fmt);
    end
    if (ready_b) begin
      fy_b  <= fy_a;
      yd_b  <= yd_a;
      c4_b  <= {1'b0, prod_lo[2*FRAC_BITS-1:FRAC_BITS]};
      c2_b  <= prod_hi[2*FRAC_BITS:FRAC_BITS];
      fmt_b <= fmt_a;
      smp_b <= smp_a;
    end
    if (ready_c) begin
      out_wgt[0] <= yd_b - c2_b;
      out_wgt[1] <= c2_b;
      out_wgt[2] <= {1'b0, fy_b} - c4_b;
      out_wgt[3] <= c4_b;
      out_fmt    <= fmt_b;
      out_smp    <= smp_b;
    end
  end

  assign out_valid = vc;

  `BPB_ASSERT_SAME(a_wgt_sum, clk, rst, vc, (SUM_W'(out_wgt[0]) + SUM_W'(out_wgt[1]) + SUM_W'(out_wgt[2]) + SUM_W'(out_wgt[3])) == SUM_W'(SCALE), "weights do not sum to scale")

endmodule

FILE: rtl/bpb_mac.sv
// ----------------------------------------------------------------------------
// bpb_mac
// two-stage multiply and rounded sum, with the output register
// ----------------------------------------------------------------------------
`include "bilinear_pixel_blend_unit_defines.svh"

module bpb_mac #(
  parameter int FRAC_BITS = bpb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpb_pkg::fmt_t                 in_fmt,
  input  logic [FRAC_BITS:0]            in_wgt [bpb_pkg::NUM_TAPS],
  input  logic [bpb_pkg::SAMPLE_W-1:0]  in_smp [bpb_pkg::NUM_TAPS],
  bpb_out_if.source                     pix_out
);

  localparam int ACC_W = FRAC_BITS + bpb_pkg::SAMPLE_W;
  localparam int MUL_W = FRAC_BITS + 1 + bpb_pkg::SAMPLE_W;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic ready_d, ready_e;
  logic vd, ve;

  logic [ACC_W-1:0]              prod_d [bpb_pkg::NUM_TAPS];
  bpb_pkg::fmt_t                 fmt_d, fmt_e;
  logic [MUL_W-1:0]              mul [bpb_pkg::NUM_TAPS];
  logic [ACC_W-1:0]              acc;
  logic [bpb_pkg::SAMPLE_W-1:0]  rnd;

  assign ready_e  = !ve || pix_out.ready;
  assign ready_d  = !vd || ready_e;
  assign in_ready = ready_d;

  always_comb begin
    for (int i = 0; i < bpb_pkg::NUM_TAPS; i++) begin
      mul[i] = in_wgt[i] * in_smp[i];
    end
  end

  assign acc = prod_d[0] + prod_d[1] + prod_d[2] + prod_d[3] + HALF;
  assign rnd = acc[ACC_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (ready_d) vd <= in_valid;
      if (ready_e) ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d) begin
      for (int i = 0; i < bpb_pkg::NUM_TAPS; i++) begin
        prod_d[i] <= mul[i][ACC_W-1:0];
      end
      fmt_d <= in_fmt;
    end
    if (ready_e) begin
      pix_out.blended <= bpb_pkg::bias_sample(rnd, fmt_d);
      fmt_e           <= fmt_d;
    end
  end

  assign pix_out.valid = ve;

  `BPB_ASSERT_SAME(a_narrow_high_zero, clk, rst, ve && !fmt_e.wide, pix_out.blended[15:8] == 8'h00, "8-bit result has high byte set")

endmodule

FILE: rtl/bilinear_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// bilinear_pixel_blend_unit
// pipeline: 3 weight stages and 2 mac stages from input transfer to result valid
// throughput: one transfer per cycle if not stalled; each stage moves on its own ready
// a stalled output holds its result while empty stages upstream keep filling
// reset (rst, synchronous): clears all stage valids and sets format to unsigned 8-bit
// ----------------------------------------------------------------------------
`include "bilinear_pixel_blend_unit_defines.svh"

module bilinear_pixel_blend_unit #(
  parameter int FRAC_BITS = bpb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bpb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bpb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  bpb_in_if.sink                           pix_in,
  bpb_out_if.source                        pix_out
);

  bpb_pkg::fmt_t                 fmt;
  logic                          w_valid, w_ready;
  bpb_pkg::fmt_t                 w_fmt;
  logic [FRAC_BITS:0]            w_wgt [bpb_pkg::NUM_TAPS];
  logic [bpb_pkg::SAMPLE_W-1:0]  w_smp [bpb_pkg::NUM_TAPS];

  bpb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fmt     (fmt)
  );

  bpb_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .pix_in    (pix_in),
    .out_valid (w_valid),
    .out_ready (w_ready),
    .out_fmt   (w_fmt),
    .out_wgt   (w_wgt),
    .out_smp   (w_smp)
  );

  bpb_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (w_valid),
    .in_ready (w_ready),
    .in_fmt   (w_fmt),
    .in_wgt   (w_wgt),
    .in_smp   (w_smp),
    .pix_out  (pix_out)
  );

  `BPB_ASSERT_SAME(a_empty_out_ready, clk, rst, !pix_out.valid, pix_in.ready, "input stalled while output register empty")

endmodule
